// ===== rtl/core/skl_pkg.sv =====
`default_nettype none

package skl_pkg;

	// Field widths fixed by the item format.
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned POS_W   = 6;
	localparam int unsigned COUNT_W = 7;

	// Request modes.
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RESULT
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/sequential_key_list_core.sv =====
// Insert and clear: once the input beat is accepted, the state register moves to S_RESULT and
// the output register then takes the result beat. Search: the scan reads one entry per cycle from
// the RAM. Delete: scan as for search up to the match, then move each later entry one place lower.
// One request is in work at a time. Reset (arst_n low) clears the sequencer, the count and the
// output valid flag; the key RAM is not cleared, since only entries below the count are ever read.
`default_nettype none

module sequential_key_list_core #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [skl_pkg::MODE_W-1:0]    mode,
	input  wire logic signed [skl_pkg::KEY_W-1:0] key,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [skl_pkg::STAT_W-1:0]    status,
	output logic      [skl_pkg::POS_W-1:0]     position,
	output logic      [skl_pkg::COUNT_W-1:0]   count
);

	import skl_pkg::*;

	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  ptr_q, ptr_d;
	logic [CNT_W-1:0]  pidx_q, pidx_d;
	logic              pend_q, pend_d;
	logic [MODE_W-1:0] mode_q, mode_d;
	logic [KEY_W-1:0]  key_q, key_d;
	logic [STAT_W-1:0] res_stat_q, res_stat_d;
	logic [CNT_W-1:0]  res_pos_q, res_pos_d;

	logic               out_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [POS_W-1:0]   position_q;
	logic [COUNT_W-1:0] count_q;

	logic              ram_wr_en;
	logic [IDX_W-1:0]  ram_wr_addr;
	logic [KEY_W-1:0]  ram_wr_data;
	logic              ram_rd_en;
	logic [IDX_W-1:0]  ram_rd_addr;
	logic [KEY_W-1:0]  ram_rd_data;

	logic              in_beat;
	logic              out_free;
	logic              hit;
	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  pidx_m1;

	// Key store.
	skl_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Shared compare unit and index arithmetic.
	assign hit     = pend_q && (ram_rd_data == key_q);
	assign cnt_m1  = cnt_q - ONE_C;
	assign pidx_m1 = pidx_q - ONE_C;

	// Sequencer: next state, RAM control and working registers.
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		ptr_d      = ptr_q;
		pidx_d     = pidx_q;
		pend_d     = pend_q;
		mode_d     = mode_q;
		key_d      = key_q;
		res_stat_d = res_stat_q;
		res_pos_d  = res_pos_q;

		ram_wr_en   = 1'b0;
		ram_wr_addr = cnt_q[IDX_W-1:0];
		ram_wr_data = key;
		ram_rd_en   = 1'b0;
		ram_rd_addr = ptr_q[IDX_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (in_beat) begin
					mode_d     = mode;
					key_d      = key;
					res_stat_d = ST_OK;
					res_pos_d  = '0;
					ptr_d      = '0;
					pend_d     = 1'b0;
					unique case (mode)
						MODE_INSERT: begin
							if (cnt_q < CAP_C) begin
								ram_wr_en = 1'b1;
								cnt_d     = cnt_q + ONE_C;
							end else begin
								res_stat_d = ST_FULL;
							end
							state_d = S_RESULT;
						end
						MODE_SEARCH, MODE_DELETE: begin
							if (cnt_q == '0) begin
								res_stat_d = ST_MISSING;
								state_d    = S_RESULT;
							end else begin
								state_d = S_SCAN;
							end
						end
						default: begin
							cnt_d   = '0;
							state_d = S_RESULT;
						end
					endcase
				end
			end

			S_SCAN: begin
				priority if (hit) begin
					if (mode_q == MODE_SEARCH) begin
						res_pos_d = pidx_q;
						state_d   = S_RESULT;
					end else begin
						ptr_d   = pidx_q + ONE_C;
						pend_d  = 1'b0;
						state_d = S_SHIFT;
					end
				end else if (pend_q && (pidx_q == cnt_m1)) begin
					res_stat_d = ST_MISSING;
					state_d    = S_RESULT;
				end else if (ptr_q < cnt_q) begin
					ram_rd_en = 1'b1;
					pidx_d    = ptr_q;
					pend_d    = 1'b1;
					ptr_d     = ptr_q + ONE_C;
				end else begin
					pend_d = 1'b0;
				end
			end

			S_SHIFT: begin
				// Write back the entry read last cycle one place lower.
				if (pend_q) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = pidx_m1[IDX_W-1:0];
					ram_wr_data = ram_rd_data;
				end
				if (ptr_q < cnt_q) begin
					ram_rd_en = 1'b1;
					pidx_d    = ptr_q;
					pend_d    = 1'b1;
					ptr_d     = ptr_q + ONE_C;
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						cnt_d   = cnt_m1;
						state_d = S_RESULT;
					end
				end
			end

			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
		end
	end

	// Working payload registers.
	always_ff @(posedge clk) begin
		ptr_q      <= ptr_d;
		pidx_q     <= pidx_d;
		mode_q     <= mode_d;
		key_q      <= key_d;
		res_stat_q <= res_stat_d;
		res_pos_q  <= res_pos_d;
	end

	// Output register holds the result until its beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_RESULT) && out_free) begin
			status_q   <= res_stat_q;
			position_q <= POS_W'(res_pos_q);
			count_q    <= COUNT_W'(cnt_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;
	assign count     = count_q;

endmodule

`default_nettype wire

// ===== rtl/core/skl_ram.sv =====
`default_nettype none

module skl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire
